FILE: src/qalu_pkg.sv
// ----------------------------------------------------------------------------
// qalu_pkg - shared definitions for the Q24.8 fixed-point ALU
// Opcodes, operation classes and the queue entry that travels from the
// front end to the execution pipeline.
// ----------------------------------------------------------------------------
package qalu_pkg;

    localparam int unsigned PORT_WIDTH     = 32;
    localparam int unsigned FUNC_WIDTH     = 4;
    localparam int unsigned DEF_FRAC_BITS  = 8;
    localparam int unsigned DEF_WORD_WIDTH = 32;
    localparam int unsigned QUEUE_DEPTH    = 2;
    localparam int unsigned QPTR_W         = $clog2(QUEUE_DEPTH);

    typedef enum logic [FUNC_WIDTH-1:0] {
        F_ADD      = 4'd0,
        F_SUB      = 4'd1,
        F_MUL      = 4'd2,
        F_DIV      = 4'd3,
        F_MIN      = 4'd4,
        F_MAX      = 4'd5,
        F_INC      = 4'd6,
        F_DEC      = 4'd7,
        F_FROM_INT = 4'd8,
        F_TO_INT   = 4'd9,
        F_EQ       = 4'd10,
        F_NE       = 4'd11,
        F_LT       = 4'd12,
        F_LE       = 4'd13,
        F_GT       = 4'd14,
        F_GE       = 4'd15
    } t_func;

    // Class of an operation, decided once in the front end.
    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic is_cmp;
    } t_cls;

    typedef struct packed {
        t_func                 func;
        t_cls                  cls;
        logic [PORT_WIDTH-1:0] a;
        logic [PORT_WIDTH-1:0] b;
    } t_item;

endpackage

FILE: src/fixed_point_q24_8_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu - signed Q24.8 fixed-point arithmetic unit
// Add, subtract, multiply, divide, min/max, step, conversions and compares
// on two raw fixed-point operands, one result per input transaction.
// ----------------------------------------------------------------------------
// Usage: the unit sustains one transaction per clock in both directions
// while the output is not held. Every transaction, whatever its opcode,
// returns its single result through the issue queue, the entry stage, the
// divider stages and the output register, in the default Q24.8 setting as
// in any other. The path length is set by the divider, which resolves one
// quotient bit per pipeline stage, and all other operations ride along the
// same stages so results leave in input order. While a result waits on
// i_stall the whole pipeline holds; the two-entry issue queue then takes up
// to two more transactions before o_stall rises. Operands are read as signed
// WORD_WIDTH-bit values and the result is sign-extended to 32 bits.
// Add, subtract, increment, decrement and integer-to-fixed wrap; multiply
// floors the shifted product and wraps; divide truncates toward zero and
// wraps, and a zero divisor returns zero with o_divide_by_zero set.
// Comparisons return zero with o_compare_true carrying the outcome.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu #(
    parameter int unsigned WORD_WIDTH = qalu_pkg::DEF_WORD_WIDTH,
    parameter int unsigned FRAC_BITS  = qalu_pkg::DEF_FRAC_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [qalu_pkg::FUNC_WIDTH-1:0]        i_func,
    input  logic signed [qalu_pkg::PORT_WIDTH-1:0] i_operand_a,
    input  logic signed [qalu_pkg::PORT_WIDTH-1:0] i_operand_b,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [qalu_pkg::PORT_WIDTH-1:0] o_value_out,
    output logic                                   o_compare_true,
    output logic                                   o_divide_by_zero
);
    import qalu_pkg::*;

    // The front end only queues and classifies, so it can keep taking
    // transactions until its queue fills while the execution pipeline is
    // held by the output.
    t_item                 head;
    logic                  head_valid;
    logic                  pop;
    logic [PORT_WIDTH-1:0] value_raw;

    qalu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_operand_a  (i_operand_a),
        .i_operand_b  (i_operand_b),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    // The back end advances whenever its output register is free or is
    // being emptied this cycle; a waiting result holds it, and intake stops
    // once the issue queue has filled behind it.
    qalu_back #(
        .WORD_WIDTH (WORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head_valid     (head_valid),
        .i_head           (head),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_value_out      (value_raw),
        .o_compare_true   (o_compare_true),
        .o_divide_by_zero (o_divide_by_zero)
    );

    assign o_value_out = $signed(value_raw);

endmodule

FILE: src/qalu_front.sv
// ----------------------------------------------------------------------------
// qalu_front - input acceptance, decode and issue queue
// Takes input transactions, tags each with its operation class and holds
// them in a short queue until the execution pipeline pulls them.
// ----------------------------------------------------------------------------
module qalu_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [qalu_pkg::FUNC_WIDTH-1:0]    i_func,
    input  logic [qalu_pkg::PORT_WIDTH-1:0]    i_operand_a,
    input  logic [qalu_pkg::PORT_WIDTH-1:0]    i_operand_b,
    output logic                               o_head_valid,
    output qalu_pkg::t_item                    o_head,
    input  logic                               i_pop
);
    import qalu_pkg::*;

    t_item               r_mem [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QPTR_W:0]     r_count;
    logic [QPTR_W:0]     n_count;
    t_item               n_item;
    logic                push;
    logic                pop;

    always_comb begin
        n_item.func = t_func'(i_func);
        n_item.a    = i_operand_a;
        n_item.b    = i_operand_b;
        n_item.cls  = '0;
        case (t_func'(i_func))
            F_MUL: begin
                n_item.cls.is_mul = 1'b1;
            end
            F_DIV: begin
                n_item.cls.is_div = 1'b1;
            end
            F_EQ, F_NE, F_LT, F_LE, F_GT, F_GE: begin
                n_item.cls.is_cmp = 1'b1;
            end
            default: begin
                n_item.cls = '0;
            end
        endcase
    end

    assign o_stall      = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign push         = i_valid && !o_stall;
    assign pop          = i_pop && o_head_valid;

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= n_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W + 1)'(QUEUE_DEPTH))
        else $error("issue queue holds more entries than it has");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted transaction was not queued");

endmodule

FILE: src/qalu_back.sv
// ----------------------------------------------------------------------------
// qalu_back - execution pipeline
// Computes simple operations and the multiply product on entry, then runs
// a one-bit-per-stage restoring divider; every operation takes the same
// path so results stay in order. Ends in the output register.
// ----------------------------------------------------------------------------
module qalu_back #(
    parameter int unsigned WORD_WIDTH = qalu_pkg::DEF_WORD_WIDTH,
    parameter int unsigned FRAC_BITS  = qalu_pkg::DEF_FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_head_valid,
    input  qalu_pkg::t_item                 i_head,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [qalu_pkg::PORT_WIDTH-1:0] o_value_out,
    output logic                            o_compare_true,
    output logic                            o_divide_by_zero
);
    import qalu_pkg::*;

    localparam int unsigned W      = WORD_WIDTH;
    localparam int unsigned DQ_W   = WORD_WIDTH + FRAC_BITS;
    localparam int unsigned PROD_W = 2 * WORD_WIDTH;
    localparam int unsigned STEPS  = DQ_W;
    localparam logic [W-1:0] ONE   = W'(1);

    // Per-stage state; stage 0 is loaded from the queue head.
    logic                   r_vld   [0:STEPS];
    t_cls                   r_cls   [0:STEPS];
    logic signed [W-1:0]    r_res   [0:STEPS];
    logic                   r_cmp   [0:STEPS];
    logic                   r_dz    [0:STEPS];
    logic                   r_neg   [0:STEPS];
    logic [W-1:0]           r_mag_b [0:STEPS];
    logic [W-1:0]           r_rem   [0:STEPS];
    logic [DQ_W-1:0]        r_dq    [0:STEPS];
    logic signed [PROD_W-1:0] r_prod;

    logic                   r_out_valid;
    logic signed [W-1:0]    r_value;
    logic                   r_cmp_out;
    logic                   r_dz_out;

    logic                   adv;
    logic signed [W-1:0]    a_w;
    logic signed [W-1:0]    b_w;
    logic [W-1:0]           mag_a;
    logic [W-1:0]           mag_b;
    logic signed [W-1:0]    n_res;
    logic                   n_cmp;
    logic signed [W-1:0]    mul_res;
    logic [W-1:0]           quo_low;
    logic signed [W-1:0]    n_value;

    assign adv   = !r_out_valid || !i_stall;
    assign o_pop = adv;

    assign a_w   = i_head.a[W-1:0];
    assign b_w   = i_head.b[W-1:0];
    assign mag_a = a_w[W-1] ? (~a_w + ONE) : a_w;
    assign mag_b = b_w[W-1] ? (~b_w + ONE) : b_w;

    always_comb begin
        n_res = '0;
        n_cmp = 1'b0;
        case (i_head.func)
            F_ADD:      n_res = a_w + b_w;
            F_SUB:      n_res = a_w - b_w;
            F_MIN:      n_res = (a_w < b_w) ? a_w : b_w;
            F_MAX:      n_res = (a_w > b_w) ? a_w : b_w;
            F_INC:      n_res = a_w + ONE;
            F_DEC:      n_res = a_w - ONE;
            F_FROM_INT: n_res = a_w <<< FRAC_BITS;
            F_TO_INT:   n_res = a_w >>> FRAC_BITS;
            F_EQ:       n_cmp = (a_w == b_w);
            F_NE:       n_cmp = (a_w != b_w);
            F_LT:       n_cmp = (a_w < b_w);
            F_LE:       n_cmp = (a_w <= b_w);
            F_GT:       n_cmp = (a_w > b_w);
            F_GE:       n_cmp = (a_w >= b_w);
            default:    n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_head_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cls[0]   <= i_head.cls;
            r_res[0]   <= n_res;
            r_cmp[0]   <= n_cmp && i_head.cls.is_cmp;
            r_dz[0]    <= i_head.cls.is_div && (b_w == '0);
            r_neg[0]   <= a_w[W-1] ^ b_w[W-1];
            r_mag_b[0] <= mag_b;
            r_rem[0]   <= '0;
            r_dq[0]    <= {mag_a, {FRAC_BITS{1'b0}}};
            r_prod     <= PROD_W'(a_w) * PROD_W'(b_w);
        end
    end

    // Arithmetic shift of the product followed by the wrap to W bits.
    assign mul_res = r_prod[FRAC_BITS +: W];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [W:0] trial;
        logic [W:0] diff;
        logic       ge;

        assign trial = {r_rem[k], r_dq[k][DQ_W-1]};
        assign diff  = trial - {1'b0, r_mag_b[k]};
        assign ge    = (trial >= {1'b0, r_mag_b[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (adv) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_cls[k+1]   <= r_cls[k];
                r_res[k+1]   <= (k == 0 && r_cls[k].is_mul) ? mul_res : r_res[k];
                r_cmp[k+1]   <= r_cmp[k];
                r_dz[k+1]    <= r_dz[k];
                r_neg[k+1]   <= r_neg[k];
                r_mag_b[k+1] <= r_mag_b[k];
                r_rem[k+1]   <= ge ? diff[W-1:0] : trial[W-1:0];
                r_dq[k+1]    <= {r_dq[k][DQ_W-2:0], ge};
            end
        end
    end

    // Quotient magnitude gets its sign back; only the low W bits survive.
    assign quo_low = r_dq[STEPS][W-1:0];

    always_comb begin
        n_value = r_res[STEPS];
        if (r_cls[STEPS].is_div) begin
            if (r_dz[STEPS]) begin
                n_value = '0;
            end else if (r_neg[STEPS]) begin
                n_value = ~quo_low + ONE;
            end else begin
                n_value = quo_low;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_vld[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_value   <= n_value;
            r_cmp_out <= r_cmp[STEPS];
            r_dz_out  <= r_dz[STEPS];
        end
    end

    assign o_valid          = r_out_valid;
    assign o_value_out      = PORT_WIDTH'(r_value);
    assign o_compare_true   = r_cmp_out;
    assign o_divide_by_zero = r_dz_out;

    a_dz_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_dz_out) |-> (r_value == '0 && !r_cmp_out))
        else $error("divide-by-zero result carries a value or compare flag");

    a_last_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_vld[STEPS]) |=> r_out_valid)
        else $error("transaction lost between last stage and output");

    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> ($stable(r_vld[STEPS]) && $stable(r_vld[0])))
        else $error("pipeline moved while the output was stalled");

endmodule

FILE: sim/fixed_point_q24_8_alu_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_tb - self-checking bench for the Q24.8 ALU
// A clocked driver sends operations from a queue with random idle cycles.
// The sink stalls at random, and a clocked monitor checks every result
// against a scoreboard of predicted results.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_tb;

    import qalu_pkg::*;

    localparam int FRAC_BITS     = DEF_FRAC_BITS;
    localparam int PIPE_LATENCY  = DEF_WORD_WIDTH + DEF_FRAC_BITS + 2;
    localparam int DRAIN_CYCLES  = PIPE_LATENCY + 16;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int RANDOM_ITEMS  = 1780;
    localparam int IDLE_PERCENT  = 37;
    localparam int BURST_FIRST   = 700;
    localparam int BURST_LAST    = 1100;
    localparam int MAX_REPORTS   = 10;

    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // One operation as it is presented on the input channel.
    typedef struct {
        t_func              func;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } alu_op_t;

    // One result as it appears on the output channel.
    typedef struct {
        logic signed [31:0] value;
        logic               cmp;
        logic               dz;
    } alu_result_t;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_valid     = 1'b0;
    logic [FUNC_WIDTH-1:0]        i_func      = '0;
    logic signed [PORT_WIDTH-1:0] i_operand_a = '0;
    logic signed [PORT_WIDTH-1:0] i_operand_b = '0;
    logic                         i_stall     = 1'b0;
    logic                         o_stall;
    logic                         o_valid;
    logic signed [PORT_WIDTH-1:0] o_value_out;
    logic                         o_compare_true;
    logic                         o_divide_by_zero;

    alu_op_t     op_queue[$];          // operations still to be sent
    alu_result_t expected_results[$];  // predicted results, oldest first
    alu_op_t     cur_op;               // operation currently on the input port
    alu_result_t oldest;
    int          sent_count   = 0;
    int          mismatches   = 0;
    int          quiet_cycles = 0;

    // Neither side idles while the accepted count lies inside this window,
    // which gives the pipeline a long stretch at full rate.
    wire burst = (sent_count >= BURST_FIRST) && (sent_count < BURST_LAST);

    fixed_point_q24_8_alu dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_operand_a      (i_operand_a),
        .i_operand_b      (i_operand_b),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_value_out      (o_value_out),
        .o_compare_true   (o_compare_true),
        .o_divide_by_zero (o_divide_by_zero)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Computes the result of one operation. Arithmetic is done at 64 bits
    // where the intermediate value can exceed the word, and the assignment
    // to the 32-bit value field performs the final wrap.
    function automatic alu_result_t alu_predict(alu_op_t op);
        logic signed [63:0] wide_a;
        logic signed [63:0] wide_b;
        logic signed [63:0] wide;
        alu_result_t        r;
        wide_a  = op.a;
        wide_b  = op.b;
        r.value = '0;
        r.cmp   = 1'b0;
        r.dz    = 1'b0;
        case (op.func)
            F_ADD:      r.value = op.a + op.b;
            F_SUB:      r.value = op.a - op.b;
            F_MUL: begin
                // The arithmetic shift floors toward minus infinity.
                wide    = wide_a * wide_b;
                r.value = wide >>> FRAC_BITS;
            end
            F_DIV: begin
                if (op.b == 0) begin
                    r.dz = 1'b1;
                end else begin
                    // Signed division truncates toward zero.
                    wide    = (wide_a <<< FRAC_BITS) / wide_b;
                    r.value = wide[31:0];
                end
            end
            F_MIN:      r.value = (op.a < op.b) ? op.a : op.b;
            F_MAX:      r.value = (op.a > op.b) ? op.a : op.b;
            F_INC:      r.value = op.a + 32'sd1;
            F_DEC:      r.value = op.a - 32'sd1;
            F_FROM_INT: r.value = op.a <<< FRAC_BITS;
            F_TO_INT:   r.value = op.a >>> FRAC_BITS;
            F_EQ:       r.cmp   = (op.a == op.b);
            F_NE:       r.cmp   = (op.a != op.b);
            F_LT:       r.cmp   = (op.a < op.b);
            F_LE:       r.cmp   = (op.a <= op.b);
            F_GT:       r.cmp   = (op.a > op.b);
            default:    r.cmp   = (op.a >= op.b);
        endcase
        return r;
    endfunction

    task automatic queue_op(t_func func, logic signed [31:0] a, logic signed [31:0] b);
        alu_op_t op;
        op.func = func;
        op.a    = a;
        op.b    = b;
        op_queue.push_back(op);
    endtask

    // Operand mix: full-range words for bit coverage, small values and whole
    // numbers for realistic arithmetic, and the corner values of the format.
    function automatic logic signed [31:0] random_operand();
        logic signed [31:0] s;
        case ($urandom_range(0, 5))
            0, 1: s = $urandom();
            2: begin
                s = $urandom_range(0, 4095);
                s = s - 32'sd2048;
            end
            3: begin
                case ($urandom_range(0, 6))
                    0:       s = Q_MAX;
                    1:       s = Q_MIN;
                    2:       s = 32'sd0;
                    3:       s = -32'sd1;
                    4:       s = 32'sd1;
                    5:       s = 32'sd256;
                    default: s = -32'sd256;
                endcase
            end
            4: begin
                s = $urandom_range(0, 200);
                s = (s - 32'sd100) <<< FRAC_BITS;
            end
            default: begin
                s = $urandom();
                s = s >>> $urandom_range(0, 31);
            end
        endcase
        return s;
    endfunction

    // Driver. The payload moves on only when the current transaction has
    // been accepted or the port is idle, so a stalled payload holds steady.
    // The expected result is recorded at the edge where the ALU takes it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) begin
                expected_results.push_back(alu_predict(cur_op));
                sent_count <= sent_count + 1;
            end
            if (op_queue.size() != 0 && (burst || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                cur_op = op_queue.pop_front();
                i_func      <= cur_op.func;
                i_operand_a <= cur_op.a;
                i_operand_b <= cur_op.b;
                i_valid     <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // The sink applies back-pressure at random outside the burst window.
    always @(posedge i_clk) begin
        i_stall <= !burst && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    task automatic report_mismatch(string what, alu_result_t exp_r);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t: %s: expected value %h cmp %b dz %b, got value %h cmp %b dz %b",
                     $realtime, what, exp_r.value, exp_r.cmp, exp_r.dz,
                     o_value_out, o_compare_true, o_divide_by_zero);
        end
    endtask

    // Monitor. Each accepted result must match the oldest prediction on
    // every field; a result with nothing predicted is an error too.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                oldest.value = 'x;
                oldest.cmp   = 1'bx;
                oldest.dz    = 1'bx;
                report_mismatch("unexpected result", oldest);
            end else begin
                oldest = expected_results.pop_front();
                if (o_value_out !== oldest.value || o_compare_true !== oldest.cmp ||
                    o_divide_by_zero !== oldest.dz) begin
                    report_mismatch("result mismatch", oldest);
                end
            end
        end
    end

    // Watchdog. The run is declared hung after a long stretch of cycles
    // in which neither channel completes a transaction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("*** FAILED ***");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        alu_op_t op;

        // Directed transactions: wrap points, rounding direction of multiply,
        // divide and the integer conversion, the zero divisor, equal operands
        // for min, max and the comparisons, and unary operations with a
        // random second operand that must be ignored.
        queue_op(F_ADD,      Q_MAX,           32'sd1);
        queue_op(F_SUB,      Q_MIN,           32'sd1);
        queue_op(F_MUL,      Q_MAX,           Q_MAX);
        queue_op(F_MUL,      Q_MIN,           Q_MIN);
        queue_op(F_MUL,      -32'sd1,         32'sd1);
        queue_op(F_MUL,      32'sd384,        -32'sd640);
        queue_op(F_DIV,      32'sd256,        32'sd0);
        queue_op(F_DIV,      Q_MIN,           -32'sd1);
        queue_op(F_DIV,      -32'sd1,         32'sd3);
        queue_op(F_MIN,      Q_MIN,           Q_MAX);
        queue_op(F_MIN,      32'sd5,          32'sd5);
        queue_op(F_MAX,      Q_MAX,           Q_MIN);
        queue_op(F_MAX,      -32'sd3,         -32'sd3);
        queue_op(F_INC,      Q_MAX,           $urandom());
        queue_op(F_DEC,      Q_MIN,           $urandom());
        queue_op(F_FROM_INT, Q_MAX,           $urandom());
        queue_op(F_FROM_INT, -32'sd1,         $urandom());
        queue_op(F_TO_INT,   -32'sd1,         $urandom());
        queue_op(F_TO_INT,   Q_MIN,           $urandom());
        queue_op(F_EQ,       Q_MIN,           Q_MIN);
        queue_op(F_NE,       32'sd0,          -32'sd1);
        queue_op(F_LT,       Q_MIN,           Q_MAX);
        queue_op(F_LE,       32'sd1,          32'sd1);
        queue_op(F_GT,       Q_MAX,           Q_MIN);
        queue_op(F_GE,       -32'sd1,         32'sd0);

        // Random transactions. Some get equal operands so the comparisons
        // and min/max see the tie, and divides get a zero divisor now and
        // then.
        repeat (RANDOM_ITEMS) begin
            op.func = t_func'($urandom_range(0, 15));
            op.a    = random_operand();
            op.b    = random_operand();
            if ($urandom_range(0, 9) == 0) begin
                op.b = op.a;
            end
            if (op.func == F_DIV && $urandom_range(0, 9) == 0) begin
                op.b = 32'sd0;
            end
            op_queue.push_back(op);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the last transaction to be taken, then for every result,
        // then a little longer so a stray extra result would be noticed.
        while (op_queue.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: fixed_point_q24_8_alu.f
src/qalu_pkg.sv
src/qalu_front.sv
src/qalu_back.sv
src/fixed_point_q24_8_alu.sv
sim/fixed_point_q24_8_alu_tb.sv
